// ===== rtl/svfdc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svfdc_pkg
// types, constants and saturation helpers for the state-variable dc blocker
// ----------------------------------------------------------------------------
package svfdc_pkg;

	localparam int SAMP_W       = 24;
	localparam int STATE_W      = 32;
	localparam int COEF_W       = 17;
	localparam int PROD_W       = 50;
	localparam int RND_W        = 34;
	localparam int SUM_W        = 35;
	localparam int OSUM_W       = 33;
	localparam int CFG_IDX_W    = 2;
	localparam int CHCNT_W      = 2;
	localparam int MAX_CHANNELS_DEF = 2;

	localparam logic [COEF_W-1:0]  COEF_LIMIT  = 17'd92682;
	localparam logic [COEF_W-1:0]  COEF_RESET  = 17'd51;
	localparam logic               ADD_RESET   = 1'b0;
	localparam logic [CHCNT_W-1:0] CHCNT_RESET = 2'd1;
	localparam logic [CHCNT_W-1:0] CHCNT_TWO   = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COEF  = 2'd0,
		CFG_ADD   = 2'd1,
		CFG_CHCNT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMP_W-1:0] in_left;
		logic signed [SAMP_W-1:0] in_right;
		logic signed [SAMP_W-1:0] prior_left;
		logic signed [SAMP_W-1:0] prior_right;
	} samp_t;

	typedef struct packed {
		logic signed [SAMP_W-1:0] out_left;
		logic signed [SAMP_W-1:0] out_right;
	} res_t;

	typedef struct packed {
		logic [COEF_W-1:0] coef;
		logic              add_mode;
	} lane_cfg_t;

	// round half up from q2.16 product to state scale
	function automatic logic signed [RND_W-1:0] coef_round(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + 50'sd32768;
		return t[PROD_W-1:16];
	endfunction

	function automatic logic signed [STATE_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [STATE_W-1:0] r;
		if (v > 35'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -35'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[STATE_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [SAMP_W-1:0] sat24(input logic signed [OSUM_W-1:0] v);
		logic signed [SAMP_W-1:0] r;
		if (v > 33'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -33'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[SAMP_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/svfdc_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svfdc_lane
// one channel of the filter: band/low state and a five-stage update chain
// ----------------------------------------------------------------------------
module svfdc_lane (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire svfdc_pkg::lane_cfg_t                cfg,
	input  wire logic signed [svfdc_pkg::SAMP_W-1:0] x,
	input  wire logic signed [svfdc_pkg::SAMP_W-1:0] prior,
	output      logic                                done,
	output      logic signed [svfdc_pkg::SAMP_W-1:0] y
);

	logic                                   v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [svfdc_pkg::PROD_W-1:0]    prod_s1, prod_s4;
	logic signed [svfdc_pkg::SAMP_W-1:0]    x_s1, prior_s1;
	logic signed [svfdc_pkg::STATE_W-1:0]   low_s2, high_s3;
	logic signed [svfdc_pkg::STATE_W-1:0]   band_q, low_q;
	logic signed [svfdc_pkg::SAMP_W-1:0]    y_q;
	logic signed [svfdc_pkg::COEF_W:0]      coef_s;
	logic signed [svfdc_pkg::SUM_W-1:0]     low_sum, high_sum, band_sum;
	logic signed [svfdc_pkg::OSUM_W-1:0]    out_sum;

	assign coef_s = $signed({1'b0, cfg.coef});

	always_comb begin
		low_sum  = svfdc_pkg::SUM_W'(low_q) + svfdc_pkg::SUM_W'(svfdc_pkg::coef_round(prod_s1));
		high_sum = svfdc_pkg::SUM_W'(x_s1 >>> 1) - svfdc_pkg::SUM_W'(low_s2)
			- svfdc_pkg::SUM_W'(band_q);
		band_sum = svfdc_pkg::SUM_W'(band_q) + svfdc_pkg::SUM_W'(svfdc_pkg::coef_round(prod_s4));
		out_sum  = svfdc_pkg::OSUM_W'(high_s3)
			+ (cfg.add_mode ? svfdc_pkg::OSUM_W'(prior_s1) : 33'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			band_q <= '0;
			low_q  <= '0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (v_s4) begin
				band_q <= svfdc_pkg::sat32(band_sum);
				low_q  <= low_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1  <= coef_s * band_q;
			x_s1     <= x;
			prior_s1 <= prior;
		end
		if (v_s1) begin
			low_s2 <= svfdc_pkg::sat32(low_sum);
		end
		if (v_s2) begin
			high_s3 <= svfdc_pkg::sat32(high_sum);
		end
		if (v_s3) begin
			prod_s4 <= coef_s * high_s3;
			y_q     <= svfdc_pkg::sat24(out_sum);
		end
	end

	assign done = v_s5;
	assign y    = y_q;

endmodule
`default_nettype wire

// ===== rtl/svfdc_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svfdc_merge
// gathers the lane results into one item and holds it in the output register
// ----------------------------------------------------------------------------
module svfdc_merge (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                lanes_done,
	input  wire logic signed [svfdc_pkg::SAMP_W-1:0] y_left,
	input  wire logic signed [svfdc_pkg::SAMP_W-1:0] y_right,
	input  wire logic                                res_stall,
	output      logic                                res_valid,
	output      svfdc_pkg::res_t                     res,
	output      logic                                retire
);

	logic            pend_q;
	logic            res_valid_q;
	svfdc_pkg::res_t res_q;
	logic            have;
	logic            load;

	assign have   = lanes_done || pend_q;
	assign load   = have && (!res_valid_q || !res_stall);
	assign retire = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			pend_q <= have && !load;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.out_left  <= y_left;
			res_q.out_right <= y_right;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

// ===== rtl/svf_highpass_dc_blocker_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svf_highpass_dc_blocker_top
// 12 db/octave dc blocker, state-variable high-pass with damping one
// ----------------------------------------------------------------------------
// One item carries a frame of up to two channels; each channel runs in its own
// lane with its own band and low state. How long a lane takes is set by its
// chain of two dependent coefficient multiplies; its result then goes to the
// output register, and the next item is taken only once that load is done,
// so one item is in the lanes at a time. While a result waits in the output
// register the next item is already accepted and filtered.
// ----------------------------------------------------------------------------
module svf_highpass_dc_blocker_top #(
	parameter int MAX_CHANNELS = svfdc_pkg::MAX_CHANNELS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   samp_valid,
	output      logic                                   samp_stall,
	input  wire svfdc_pkg::samp_t                       samp,
	output      logic                                   res_valid,
	input  wire logic                                   res_stall,
	output      svfdc_pkg::res_t                        res,
	input  wire logic                                   cfg_valid,
	output      logic                                   cfg_ready,
	input  wire logic [svfdc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [svfdc_pkg::COEF_W-1:0]           cfg_data
);

	logic [svfdc_pkg::COEF_W-1:0]  coef_q;
	logic                          add_q;
	logic [svfdc_pkg::CHCNT_W-1:0] chcnt_q;
	logic                          busy_q;
	logic                          accept;
	logic                          two_ch;
	logic                          retire;
	svfdc_pkg::lane_cfg_t          lane_cfg;
	logic [MAX_CHANNELS-1:0]       lane_done;
	logic signed [svfdc_pkg::SAMP_W-1:0] lane_y [MAX_CHANNELS];
	logic signed [svfdc_pkg::SAMP_W-1:0] right_y;

	assign cfg_ready  = 1'b1;
	assign accept     = samp_valid && !samp_stall;
	assign samp_stall = busy_q;
	assign two_ch     = (MAX_CHANNELS > 1) && (chcnt_q >= svfdc_pkg::CHCNT_TWO);

	assign lane_cfg.coef     = (coef_q > svfdc_pkg::COEF_LIMIT) ? svfdc_pkg::COEF_LIMIT : coef_q;
	assign lane_cfg.add_mode = add_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q  <= svfdc_pkg::COEF_RESET;
			add_q   <= svfdc_pkg::ADD_RESET;
			chcnt_q <= svfdc_pkg::CHCNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (svfdc_pkg::cfg_reg_t'(cfg_index))
				svfdc_pkg::CFG_COEF: begin
					coef_q <= cfg_data;
				end
				svfdc_pkg::CFG_ADD: begin
					add_q <= cfg_data[0];
				end
				svfdc_pkg::CFG_CHCNT: begin
					chcnt_q <= cfg_data[svfdc_pkg::CHCNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (retire) begin
			busy_q <= 1'b0;
		end
	end

	for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
		svfdc_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (accept && ((c == 0) || two_ch)),
			.cfg    (lane_cfg),
			.x      ((c == 0) ? samp.in_left : samp.in_right),
			.prior  ((c == 0) ? samp.prior_left : samp.prior_right),
			.done   (lane_done[c]),
			.y      (lane_y[c])
		);
	end

	assign right_y = two_ch ? lane_y[MAX_CHANNELS-1] : '0;

	svfdc_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.lanes_done (|lane_done),
		.y_left     (lane_y[0]),
		.y_right    (right_y),
		.res_stall  (res_stall),
		.res_valid  (res_valid),
		.res        (res),
		.retire     (retire)
	);

endmodule
`default_nettype wire

// ===== rtl/svfdc_check.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svfdc_check
// port-level checks for the dc blocker, bound to the top level
// ----------------------------------------------------------------------------
module svfdc_check (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             samp_valid,
	input wire logic             samp_stall,
	input wire logic             res_valid,
	input wire logic             res_stall,
	input wire svfdc_pkg::res_t  res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result item changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		samp_valid && !samp_stall |=> samp_stall)
		else $error("item taken while previous item in flight");

	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		samp_valid && !samp_stall |=> ##3 samp_stall)
		else $error("lane chain finished too early");

	a_release_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(samp_stall) |-> res_valid)
		else $error("input released without a result in the output register");

endmodule

bind svf_highpass_dc_blocker_top svfdc_check u_svfdc_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.samp_valid (samp_valid),
	.samp_stall (samp_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res        (res)
);
`default_nettype wire

// ===== tb/svf_highpass_dc_blocker_check.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svf_highpass_dc_blocker_check
// watches the item, result and register channels of the dc blocker, keeps its
// own model of the two filter lanes and compares every result in order
// ----------------------------------------------------------------------------
module svf_highpass_dc_blocker_check #(
	parameter int MAX_CHANNELS = svfdc_pkg::MAX_CHANNELS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            samp_valid,
	input  wire logic                            samp_stall,
	input  wire svfdc_pkg::samp_t                samp,
	input  wire logic                            res_valid,
	input  wire logic                            res_stall,
	input  wire svfdc_pkg::res_t                 res,
	input  wire logic                            cfg_valid,
	input  wire logic                            cfg_ready,
	input  wire logic [svfdc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [svfdc_pkg::COEF_W-1:0]    cfg_data,
	output int                                   errors,
	output int                                   pending,
	output int                                   results,
	output int                                   frames
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [svfdc_pkg::COEF_W-1:0]         coef_r;
	logic                                 add_r;
	logic [svfdc_pkg::CHCNT_W-1:0]        chcnt_r;
	logic signed [svfdc_pkg::STATE_W-1:0] bp_mem [MAX_CHANNELS];
	logic signed [svfdc_pkg::STATE_W-1:0] lp_mem [MAX_CHANNELS];
	svfdc_pkg::res_t                      out_q [$];

	task automatic report_mismatch(string msg);
		$display("%0t mismatch: %s", $time, msg);
		errors++;
	endtask

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic logic signed [svfdc_pkg::SAMP_W-1:0] clamp24(longint v);
		if (v > 64'sd8388607) begin
			return 24'sh7FFFFF;
		end
		if (v < -64'sd8388608) begin
			return 24'sh800000;
		end
		return v[svfdc_pkg::SAMP_W-1:0];
	endfunction

	// q2.16 coefficient times state value, rounded half up
	function automatic longint mul_coef(longint f, longint v);
		return (f * v + 64'sd32768) >>> 16;
	endfunction

	function automatic logic signed [svfdc_pkg::SAMP_W-1:0] hp_step(int c,
			logic signed [svfdc_pkg::SAMP_W-1:0] x,
			logic signed [svfdc_pkg::SAMP_W-1:0] prior);
		longint f, d1, lp, hp, bp, xs, y;
		f = (coef_r > svfdc_pkg::COEF_LIMIT) ? longint'(svfdc_pkg::COEF_LIMIT)
			: longint'(coef_r);
		d1 = bp_mem[c];
		xs = x;
		lp = clamp32(longint'(lp_mem[c]) + mul_coef(f, d1));
		hp = clamp32((xs >>> 1) - lp - d1);
		bp = clamp32(d1 + mul_coef(f, hp));
		bp_mem[c] = bp[svfdc_pkg::STATE_W-1:0];
		lp_mem[c] = lp[svfdc_pkg::STATE_W-1:0];
		y = hp;
		if (add_r) begin
			y = y + longint'(prior);
		end
		return clamp24(y);
	endfunction

	function automatic svfdc_pkg::res_t filter_frame(svfdc_pkg::samp_t s);
		svfdc_pkg::res_t r;
		int              lanes;
		lanes = (chcnt_r >= svfdc_pkg::CHCNT_TWO) ? 2 : 1;
		if (lanes > MAX_CHANNELS) begin
			lanes = MAX_CHANNELS;
		end
		r.out_left = hp_step(0, s.in_left, s.prior_left);
		r.out_right = '0;
		if (lanes >= 2) begin
			r.out_right = hp_step(lanes - 1, s.in_right, s.prior_right);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		svfdc_pkg::res_t want;
		if (!arst_n) begin
			coef_r = svfdc_pkg::COEF_RESET;
			add_r = svfdc_pkg::ADD_RESET;
			chcnt_r = svfdc_pkg::CHCNT_RESET;
			for (int c = 0; c < MAX_CHANNELS; c++) begin
				bp_mem[c] = '0;
				lp_mem[c] = '0;
			end
			out_q.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (svfdc_pkg::cfg_reg_t'(cfg_index))
					svfdc_pkg::CFG_COEF: begin
						coef_r = cfg_data;
					end
					svfdc_pkg::CFG_ADD: begin
						add_r = cfg_data[0];
					end
					svfdc_pkg::CFG_CHCNT: begin
						chcnt_r = cfg_data[svfdc_pkg::CHCNT_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (res_valid && !res_stall) begin
				results++;
				if (out_q.size() == 0) begin
					report_mismatch($sformatf("result %h with no item pending", res));
				end else begin
					want = out_q.pop_front();
					if (res.out_left !== want.out_left) begin
						report_mismatch($sformatf("out_left got %0d want %0d",
							res.out_left, want.out_left));
					end
					if (res.out_right !== want.out_right) begin
						report_mismatch($sformatf("out_right got %0d want %0d",
							res.out_right, want.out_right));
					end
				end
			end
			if (samp_valid && !samp_stall) begin
				out_q.push_back(filter_frame(samp));
				frames++;
			end
			pending = out_q.size();
		end
	end

endmodule
`default_nettype wire

// ===== tb/svf_highpass_dc_blocker_top_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svf_highpass_dc_blocker_top_test
// drives the dc blocker with directed extremes under several register settings,
// then random phases with random gaps, receiver stalls and one long hold-off
// ----------------------------------------------------------------------------
module svf_highpass_dc_blocker_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT    = 3000;
	localparam int SQUEEZE_CYCLES = 400;
	localparam int SQUEEZE_AT     = 150;
	localparam logic signed [svfdc_pkg::SAMP_W-1:0] S_MAX  = 24'sh7FFFFF;
	localparam logic signed [svfdc_pkg::SAMP_W-1:0] S_MIN  = 24'sh800000;
	localparam logic signed [svfdc_pkg::SAMP_W-1:0] S_ONE  = 24'sd1;
	localparam logic signed [svfdc_pkg::SAMP_W-1:0] S_NEG1 = -24'sd1;

	logic                            clk;
	logic                            arst_n;
	logic                            samp_valid;
	logic                            samp_stall;
	svfdc_pkg::samp_t                samp;
	logic                            res_valid;
	logic                            res_stall;
	svfdc_pkg::res_t                 res;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [svfdc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [svfdc_pkg::COEF_W-1:0]    cfg_data;

	int errors;
	int pending;
	int results;
	int frames;
	int n_sent;
	int n_cfg;
	bit dense;
	bit squeezed;
	int dc_level;

	svf_highpass_dc_blocker_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.samp_valid (samp_valid),
		.samp_stall (samp_stall),
		.samp       (samp),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	svf_highpass_dc_blocker_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.samp_valid (samp_valid),
		.samp_stall (samp_stall),
		.samp       (samp),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.errors     (errors),
		.pending    (pending),
		.results    (results),
		.frames     (frames)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int pick_gap();
		int r;
		if (dense) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 96) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 80);
	endfunction

	function automatic int stall_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 3);
		end
		if (r < 94) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 80);
	endfunction

	function automatic logic signed [svfdc_pkg::SAMP_W-1:0] pick_samp();
		int r;
		r = $urandom_range(0, 19);
		unique case (r)
			0: begin
				return S_MAX;
			end
			1: begin
				return S_MIN;
			end
			2, 3: begin
				return svfdc_pkg::SAMP_W'(int'($urandom_range(0, 511)) - 256);
			end
			4, 5, 6: begin
				return svfdc_pkg::SAMP_W'(dc_level + int'($urandom_range(0, 63)) - 32);
			end
			default: begin
				return svfdc_pkg::SAMP_W'($urandom);
			end
		endcase
	endfunction

	function automatic logic [svfdc_pkg::COEF_W-1:0] pick_coef();
		unique case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return svfdc_pkg::COEF_LIMIT;
			end
			2: begin
				return svfdc_pkg::COEF_LIMIT + 17'd1;
			end
			3: begin
				return '1;
			end
			4: begin
				return svfdc_pkg::COEF_RESET;
			end
			5, 6: begin
				return svfdc_pkg::COEF_W'($urandom_range(0, 131071));
			end
			default: begin
				return svfdc_pkg::COEF_W'($urandom_range(1, 20000));
			end
		endcase
	endfunction

	function automatic svfdc_pkg::samp_t frame(logic signed [svfdc_pkg::SAMP_W-1:0] l,
			logic signed [svfdc_pkg::SAMP_W-1:0] r,
			logic signed [svfdc_pkg::SAMP_W-1:0] pl,
			logic signed [svfdc_pkg::SAMP_W-1:0] pr);
		svfdc_pkg::samp_t s;
		s.in_left = l;
		s.in_right = r;
		s.prior_left = pl;
		s.prior_right = pr;
		return s;
	endfunction

	task automatic send_frame(svfdc_pkg::samp_t s);
		int g;
		g = pick_gap();
		if (g > 0) begin
			samp_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		samp_valid <= 1'b1;
		samp <= s;
		do @(posedge clk); while (samp_stall);
		n_sent++;
	endtask

	task automatic drain();
		samp_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic configure(logic [svfdc_pkg::COEF_W-1:0] coef,
			logic [svfdc_pkg::COEF_W-1:0] add, logic [svfdc_pkg::COEF_W-1:0] chans);
		svfdc_pkg::cfg_reg_t          regs [3];
		logic [svfdc_pkg::COEF_W-1:0] vals [3];
		regs = '{svfdc_pkg::CFG_COEF, svfdc_pkg::CFG_ADD, svfdc_pkg::CFG_CHCNT};
		vals = '{coef, add, chans};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			n_cfg++;
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((samp_valid && !samp_stall) || (res_valid && !res_stall)
					|| (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("timeout after %0d quiet cycles, %0d items pending", QUIET_LIMIT, pending);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : sink
		int n;
		res_stall <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!squeezed && n_sent >= SQUEEZE_AT) begin
				squeezed = 1'b1;
				res_stall <= 1'b1;
				n = 0;
				while (n < SQUEEZE_CYCLES) begin
					@(posedge clk);
					n++;
				end
				res_stall <= 1'b0;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				res_stall <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end else begin
				n = stall_len();
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
				res_stall <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int ph;
		arst_n <= 1'b0;
		samp_valid <= 1'b0;
		samp <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= svfdc_pkg::CFG_COEF;
		cfg_data <= '0;
		dense = 1'b0;
		dc_level = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one channel, replace, small coefficient
		send_frame(frame(S_MAX, S_MIN, S_MAX, S_MIN));
		send_frame(frame(S_MIN, S_MAX, S_MIN, S_MAX));
		send_frame(frame('0, '0, '0, '0));
		send_frame(frame(S_NEG1, S_ONE, S_NEG1, S_ONE));
		send_frame(frame(S_MAX, S_MAX, S_MIN, S_MIN));

		// two channels, add mode, coefficient at its stable limit
		drain();
		configure(svfdc_pkg::COEF_LIMIT, 17'd1, svfdc_pkg::COEF_W'(svfdc_pkg::CHCNT_TWO));
		send_frame(frame(S_MAX, S_MAX, S_MAX, S_MAX));
		send_frame(frame(S_MAX, S_MAX, S_MAX, S_MAX));
		send_frame(frame(S_MIN, S_MIN, S_MIN, S_MIN));
		send_frame(frame(S_MIN, S_MIN, S_MIN, S_MIN));
		send_frame(frame(S_MAX, S_MIN, S_MIN, S_MAX));
		send_frame(frame('0, '0, S_MAX, S_MIN));

		// coefficient field all ones is clamped, count of three acts as two
		drain();
		configure('1, 17'd0, svfdc_pkg::COEF_W'(svfdc_pkg::CHCNT_TWO + 2'd1));
		send_frame(frame(S_MAX, S_MIN, '0, '0));
		send_frame(frame(S_MIN, S_MAX, '0, '0));
		send_frame(frame(S_MAX, S_MIN, S_MAX, S_MIN));
		send_frame(frame('0, '0, '0, '0));

		// zero coefficient, count of zero acts as one
		drain();
		configure('0, 17'd1, '0);
		send_frame(frame(S_MAX, S_MAX, S_MIN, S_MIN));
		send_frame(frame(S_MIN, S_MIN, S_MAX, S_MAX));
		send_frame(frame(S_ONE, S_NEG1, S_NEG1, S_ONE));

		drain();
		configure(17'd1, 17'd0, svfdc_pkg::COEF_W'(svfdc_pkg::CHCNT_RESET));
		send_frame(frame(S_MAX, S_MIN, S_MAX, S_MIN));
		send_frame(frame(S_MIN, S_MAX, S_MIN, S_MAX));

		for (ph = 0; ph < 8; ph++) begin
			drain();
			configure(pick_coef(), svfdc_pkg::COEF_W'($urandom),
				svfdc_pkg::COEF_W'($urandom));
			dense = ($urandom_range(0, 3) == 0);
			dc_level = int'($urandom_range(0, 16777215)) - 8388608;
			repeat (60) send_frame(frame(pick_samp(), pick_samp(), pick_samp(), pick_samp()));
		end

		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d items and %0d results over %0d register writes,", frames, results,
			n_cfg);
		$display("one and two channels, add and replace, coefficients zero to all ones");
		if (errors == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, pending);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
`default_nettype wire
